// ===== rtl/hpwm_pkg.sv =====
// Shared types, codes and arithmetic constants for the H-bridge motor channel.
`default_nettype none

package hpwm_pkg;

    // Defaults for the top-level parameters.
    localparam int ENCODER_WIDTH_DEFAULT = 16;
    localparam int PWM_WIDTH_DEFAULT     = 16;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENCODER_MAX = 2'd1;
    localparam logic [15:0] PWM_PERIOD_RESET  = 16'hFFFF;
    localparam logic [15:0] ENCODER_MAX_RESET = 16'hFFFF;

    // Duty clamp and coast threshold, in hundredths of a percent.
    localparam logic signed [15:0] DUTY_MAX = 16'sd10000;
    localparam logic signed [15:0] DUTY_MIN = -16'sd10000;
    localparam int DUTY_MAG_W  = 14;
    localparam int COAST_LIMIT = 10;
    localparam int PCT_W       = 7;
    localparam int ROUND_BIAS  = 50;

    // Division by 100 as multiply by reciprocal and shift. The first is exact for
    // magnitudes up to 10000, the second for dividends below 2^23.
    localparam int PCT_RECIP   = 10486;
    localparam int PCT_SHIFT   = 20;
    localparam int PCT_PROD_W  = 28;
    localparam int CMP_RECIP   = 10737419;
    localparam int CMP_RECIP_W = 24;
    localparam int CMP_SHIFT   = 30;

    typedef enum logic [1:0] {
        MODE_DUTY = 2'd0,
        MODE_DIR  = 2'd1,
        MODE_STOP = 2'd2,
        MODE_READ = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        DIR_FORWARD  = 2'd0,
        DIR_BACKWARD = 2'd1,
        DIR_COAST    = 2'd2,
        DIR_BRAKE    = 2'd3
    } dir_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [15:0] duty_hundredths;
        dir_t               direction_request;
        logic [15:0]        encoder_count;
    } cmd_t;

    typedef struct packed {
        logic               bridge_in1;
        logic               bridge_in2;
        logic [15:0]        compare_value;
        dir_t               direction_now;
        logic signed [7:0]  duty_percent;
        logic signed [31:0] total_ticks;
    } res_t;

    // A request in flight with its duty decoded.
    typedef struct packed {
        cmd_t              cmd;
        logic [PCT_W-1:0]  pct;
        dir_t              duty_dir;
        logic signed [7:0] duty_pct;
    } pipe_item_t;

endpackage

`default_nettype wire

// ===== rtl/hbridge_pwm_motor_with_encoder_unwrap.sv =====
// Top level of one H-bridge PWM motor channel with encoder position unwrap.
//
//   channel   signals                              direction
//   cfg       cfg_valid cfg_ready cfg_index cfg_data  write in
//   cmd       cmd_valid cmd_ready cmd                  request in
//   res       res_valid res_ready res                  result out
//
// One request is taken every cycle while the result is not held; requests pass through
// the duty scaling stages: input register, percent extraction, period product,
// and the divide and state update that loads the result register.
// Reset sets the direction to coast and clears ticks, duty and compare; the period
// and encoder maximum return to all ones. A held result stalls the stages behind it,
// one at a time, so a request is still taken while earlier stages have room.
`default_nettype none

module hbridge_pwm_motor_with_encoder_unwrap #(
    parameter int ENCODER_WIDTH = hpwm_pkg::ENCODER_WIDTH_DEFAULT,
    parameter int PWM_WIDTH     = hpwm_pkg::PWM_WIDTH_DEFAULT
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [hpwm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [15:0]                       cfg_data,
    input  wire                               cmd_valid,
    output logic                              cmd_ready,
    input  hpwm_pkg::cmd_t                    cmd,
    output logic                              res_valid,
    input  wire                               res_ready,
    output hpwm_pkg::res_t                    res
);
    import hpwm_pkg::*;

    logic [15:0] pwm_period_reg;
    logic [15:0] encoder_max_reg;

    logic                   item_valid;
    logic                   item_ready;
    pipe_item_t             item;
    logic [PWM_WIDTH+6:0]   scaled;
    logic [PWM_WIDTH-1:0]   period;

    assign cfg_ready = 1'b1;
    assign period    = pwm_period_reg[PWM_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg  <= PWM_PERIOD_RESET;
            encoder_max_reg <= ENCODER_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PWM_PERIOD:
                begin
                    pwm_period_reg <= cfg_data;
                end
                CFG_ENCODER_MAX:
                begin
                    encoder_max_reg <= cfg_data;
                end
                default:
                begin
                    pwm_period_reg <= pwm_period_reg;
                end
            endcase
        end
    end

    hpwm_duty_pipe #(
        .PWM_WIDTH(PWM_WIDTH)
    ) u_duty_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .period     (period),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .scaled     (scaled)
    );

    hpwm_channel #(
        .ENCODER_WIDTH(ENCODER_WIDTH),
        .PWM_WIDTH    (PWM_WIDTH)
    ) u_channel (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .scaled      (scaled),
        .period      (period),
        .encoder_max (encoder_max_reg[ENCODER_WIDTH-1:0]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // The bridge pins always decode the reported direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.bridge_in1 == (res.direction_now == DIR_FORWARD ||
                                          res.direction_now == DIR_BRAKE)) &&
                      (res.bridge_in2 == (res.direction_now == DIR_BACKWARD ||
                                          res.direction_now == DIR_BRAKE)))
        else $error("bridge pins disagree with direction");

    // Duty stays within plus or minus one hundred percent.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.duty_percent <= 8'sd100) && (res.duty_percent >= -8'sd100))
        else $error("duty percent out of range");

    // An emergency stop leaves zero ticks, zero duty and zero compare behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.cmd.mode == MODE_STOP) |=>
            (res_valid && res.total_ticks == 32'sd0 && res.duty_percent == 8'sd0 &&
             res.compare_value == 16'd0))
        else $error("emergency stop did not clear state");

endmodule

`default_nettype wire

// ===== rtl/hpwm_duty_pipe.sv =====
// Input register and duty scaling stages: percent extraction, then period product.
`default_nettype none

module hpwm_duty_pipe #(
    parameter int PWM_WIDTH = hpwm_pkg::PWM_WIDTH_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cmd_valid,
    output logic                         cmd_ready,
    input  hpwm_pkg::cmd_t               cmd,
    input  wire  [PWM_WIDTH-1:0]         period,
    output logic                         item_valid,
    input  wire                          item_ready,
    output hpwm_pkg::pipe_item_t         item,
    output logic [PWM_WIDTH+6:0]         scaled
);
    import hpwm_pkg::*;

    localparam int PROD_W = PWM_WIDTH + PCT_W;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    cmd_t       s1_cmd_reg;
    pipe_item_t s2_item_reg, s3_item_reg;
    logic [PROD_W-1:0] s3_scaled_reg;

    logic en1, en2, en3;
    pipe_item_t s2_next;
    logic [PROD_W-1:0] s3_scaled_next;

    logic signed [15:0]      d_clamp;
    logic                    neg;
    logic [DUTY_MAG_W-1:0]   mag;
    logic [PCT_PROD_W-1:0]   pct_prod;
    logic [PCT_W-1:0]        pct;
    logic signed [7:0]       pct_s;

    // Each stage loads when it is empty or its content moves on.
    assign en3       = !s3_valid_reg || item_ready;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign cmd_ready = en1;

    always_comb
    begin
        if (s1_cmd_reg.duty_hundredths > DUTY_MAX)
        begin
            d_clamp = DUTY_MAX;
        end
        else if (s1_cmd_reg.duty_hundredths < DUTY_MIN)
        begin
            d_clamp = DUTY_MIN;
        end
        else
        begin
            d_clamp = s1_cmd_reg.duty_hundredths;
        end
        neg      = d_clamp[15];
        mag      = neg ? DUTY_MAG_W'(-d_clamp) : d_clamp[DUTY_MAG_W-1:0];
        pct_prod = PCT_PROD_W'(mag) * PCT_PROD_W'(PCT_RECIP);
        pct      = pct_prod[PCT_SHIFT +: PCT_W];
        pct_s    = $signed({1'b0, pct});

        s2_next.cmd      = s1_cmd_reg;
        s2_next.pct      = pct;
        s2_next.duty_pct = neg ? -pct_s : pct_s;
        if (mag < DUTY_MAG_W'(COAST_LIMIT))
        begin
            s2_next.duty_dir = DIR_COAST;
        end
        else
        begin
            s2_next.duty_dir = neg ? DIR_BACKWARD : DIR_FORWARD;
        end
    end

    assign s3_scaled_next = PROD_W'(s2_item_reg.pct) * PROD_W'(period)
                          + PROD_W'(ROUND_BIAS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && cmd_valid)
        begin
            s1_cmd_reg <= cmd;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_item_reg <= s2_next;
        end
        if (en3 && s2_valid_reg)
        begin
            s3_item_reg   <= s2_item_reg;
            s3_scaled_reg <= s3_scaled_next;
        end
    end

    assign item_valid = s3_valid_reg;
    assign item       = s3_item_reg;
    assign scaled     = s3_scaled_reg;

endmodule

`default_nettype wire

// ===== rtl/hpwm_channel.sv =====
// Channel state (direction, compare, duty, encoder total) and the result register.
`default_nettype none

module hpwm_channel #(
    parameter int ENCODER_WIDTH = hpwm_pkg::ENCODER_WIDTH_DEFAULT,
    parameter int PWM_WIDTH     = hpwm_pkg::PWM_WIDTH_DEFAULT
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        item_valid,
    output logic                       item_ready,
    input  hpwm_pkg::pipe_item_t       item,
    input  wire  [PWM_WIDTH+6:0]       scaled,
    input  wire  [PWM_WIDTH-1:0]       period,
    input  wire  [ENCODER_WIDTH-1:0]   encoder_max,
    output logic                       res_valid,
    input  wire                        res_ready,
    output hpwm_pkg::res_t             res
);
    import hpwm_pkg::*;

    localparam int PROD_W = PWM_WIDTH + PCT_W;
    localparam int QP_W   = PROD_W + CMP_RECIP_W;
    localparam int DW     = ENCODER_WIDTH + 2;

    dir_t                  dir_reg, dir_next;
    logic [31:0]           tick_reg, tick_next;
    logic signed [7:0]     duty_reg, duty_next;
    logic [PWM_WIDTH-1:0]  cmp_reg, cmp_next;
    logic                  res_valid_reg;
    res_t                  res_reg, res_next;

    logic                  take;
    logic [QP_W-1:0]       q_prod;
    logic [PWM_WIDTH-1:0]  q;
    logic [PWM_WIDTH-1:0]  cmp_duty;

    logic [ENCODER_WIDTH-1:0] maxv, half, last, cnt;
    logic signed [DW-1:0]     delta, span, half_s, adj;

    assign item_ready = !res_valid_reg || res_ready;
    assign take       = item_valid && item_ready;

    // Compare value: scaled / 100, capped at the period.
    assign q_prod   = QP_W'(scaled) * QP_W'(CMP_RECIP);
    assign q        = q_prod[CMP_SHIFT +: PWM_WIDTH];
    assign cmp_duty = (q > period) ? period : q;

    // Unwrap the raw counter against the masked running total.
    always_comb
    begin
        maxv   = (encoder_max == '0) ? '1 : encoder_max;
        half   = maxv >> 1;
        last   = tick_reg[ENCODER_WIDTH-1:0] & maxv;
        cnt    = item.cmd.encoder_count[ENCODER_WIDTH-1:0];
        delta  = $signed({2'b00, cnt}) - $signed({2'b00, last});
        span   = $signed(DW'(maxv) + DW'(1));
        half_s = $signed({2'b00, half});
        if (delta > half_s)
        begin
            adj = delta - span;
        end
        else if (delta < -half_s)
        begin
            adj = delta + span;
        end
        else
        begin
            adj = delta;
        end
    end

    always_comb
    begin
        dir_next  = dir_reg;
        tick_next = tick_reg;
        duty_next = duty_reg;
        cmp_next  = cmp_reg;
        case (item.cmd.mode)
            MODE_DUTY:
            begin
                cmp_next  = cmp_duty;
                dir_next  = item.duty_dir;
                duty_next = item.duty_pct;
            end
            MODE_DIR:
            begin
                dir_next = item.cmd.direction_request;
            end
            MODE_STOP:
            begin
                cmp_next  = '0;
                dir_next  = DIR_BRAKE;
                tick_next = '0;
                duty_next = '0;
            end
            MODE_READ:
            begin
                tick_next = tick_reg + {{(32 - DW){adj[DW-1]}}, adj};
            end
            default:
            begin
                dir_next = dir_reg;
            end
        endcase

        res_next.bridge_in1    = (dir_next == DIR_FORWARD) || (dir_next == DIR_BRAKE);
        res_next.bridge_in2    = (dir_next == DIR_BACKWARD) || (dir_next == DIR_BRAKE);
        res_next.compare_value = 16'(cmp_next);
        res_next.direction_now = dir_next;
        res_next.duty_percent  = duty_next;
        res_next.total_ticks   = $signed(tick_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= DIR_COAST;
            tick_reg      <= '0;
            duty_reg      <= '0;
            cmp_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                dir_reg       <= dir_next;
                tick_reg      <= tick_next;
                duty_reg      <= duty_next;
                cmp_reg       <= cmp_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== tb/sv/hbridge_pwm_motor_with_encoder_unwrap_test.sv =====
// Self-checking testbench for the H-bridge PWM motor channel with encoder unwrap.
module hbridge_pwm_motor_with_encoder_unwrap_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hpwm_pkg::*;

    localparam int DUTY_LIMIT      = 10000;
    localparam int COAST_BELOW     = 10;
    localparam int ENC_ALL_ONES    = (1 << ENCODER_WIDTH_DEFAULT) - 1;
    localparam int GAP_MAX         = 12;
    localparam int LONG_HOLD       = 150;
    localparam int SETTLE_CYCLES   = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 166;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_t        cmd       = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_t        res;

    // Channel state as the block should hold it, plus its register settings.
    logic [15:0]       period_setting = PWM_PERIOD_RESET;
    logic [15:0]       encmax_setting = ENCODER_MAX_RESET;
    dir_t              motor_dir      = DIR_COAST;
    logic [31:0]       motor_ticks    = '0;
    logic signed [7:0] motor_duty     = '0;
    logic [15:0]       motor_compare  = '0;

    cmd_t cmd_backlog[$];
    res_t status_due[$];

    int mismatch_count  = 0;
    int send_gap_max    = 0;
    int recv_gap_max    = 0;
    int send_wait       = 0;
    int recv_wait       = 0;
    int hold_left       = 0;
    int holds_requested = 0;
    int holds_served    = 0;
    int quiet_cycles    = 0;
    int raw_position    = 0;

    hbridge_pwm_motor_with_encoder_unwrap u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one request to the channel state and returns the status it should report.
    function automatic res_t apply_command(cmd_t c);
        int   duty;
        int   mag;
        int   pct;
        int   level;
        int   span_max;
        int   half;
        int   delta;
        res_t status;
        case (c.mode)
            MODE_DUTY:
            begin
                duty = $signed(c.duty_hundredths);
                if (duty > DUTY_LIMIT)
                    duty = DUTY_LIMIT;
                if (duty < -DUTY_LIMIT)
                    duty = -DUTY_LIMIT;
                mag   = (duty < 0) ? -duty : duty;
                pct   = mag / 100;
                level = (pct * int'(period_setting) + 50) / 100;
                if (level > int'(period_setting))
                    level = int'(period_setting);
                if (mag < COAST_BELOW)
                    motor_dir = DIR_COAST;
                else if (duty > 0)
                    motor_dir = DIR_FORWARD;
                else
                    motor_dir = DIR_BACKWARD;
                motor_compare = 16'(level);
                motor_duty    = 8'((duty < 0) ? -pct : pct);
            end
            MODE_DIR:
                motor_dir = c.direction_request;
            MODE_STOP:
            begin
                motor_compare = '0;
                motor_dir     = DIR_BRAKE;
                motor_ticks   = '0;
                motor_duty    = '0;
            end
            default:
            begin
                span_max = int'(encmax_setting);
                if (span_max == 0)
                    span_max = ENC_ALL_ONES;
                half  = span_max / 2;
                delta = int'(c.encoder_count) - int'(motor_ticks & 32'(span_max));
                // Signed unwrap at half range.
                if (delta > half)
                    delta = delta - (span_max + 1);
                else if (delta < -half)
                    delta = delta + (span_max + 1);
                motor_ticks = motor_ticks + 32'(delta);
            end
        endcase
        status.bridge_in1    = (motor_dir == DIR_FORWARD) || (motor_dir == DIR_BRAKE);
        status.bridge_in2    = (motor_dir == DIR_BACKWARD) || (motor_dir == DIR_BRAKE);
        status.compare_value = motor_compare;
        status.direction_now = motor_dir;
        status.duty_percent  = motor_duty;
        status.total_ticks   = motor_ticks;
        return status;
    endfunction

    function automatic int draw_gap(int gap_max);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return int'($urandom_range(0, gap_max));
    endfunction

    // Random request; the duty field is shaped for duty requests and the count for reads, the others are noise.
    function automatic cmd_t make_command();
        cmd_t c;
        int   pick;
        int   duty;
        int   span;
        int   reach;
        int   step;
        pick = $urandom_range(0, 99);
        c.duty_hundredths   = 16'($urandom);
        c.direction_request = dir_t'($urandom_range(0, 3));
        c.encoder_count     = 16'($urandom);
        if (pick < 30)
            c.mode = MODE_DUTY;
        else if (pick < 48)
            c.mode = MODE_DIR;
        else if (pick < 53)
            c.mode = MODE_STOP;
        else
            c.mode = MODE_READ;

        if (c.mode == MODE_DUTY)
        begin
            case ($urandom_range(0, 6))
                0, 1, 2: duty = int'($urandom_range(0, 20000)) - DUTY_LIMIT;
                3:       duty = int'($urandom_range(0, 40)) - 20;
                4:       duty = int'($urandom_range(0, 100)) * 100 + int'($urandom_range(0, 2)) - 1;
                5:       duty = int'($urandom_range(0, 65535)) - 32768;
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       duty = -32768;
                        1:       duty = -10001;
                        2:       duty = -DUTY_LIMIT;
                        3:       duty = DUTY_LIMIT;
                        4:       duty = 10001;
                        default: duty = 32767;
                    endcase
                end
            endcase
            if (pick % 2 == 1 && duty > 0 && duty <= DUTY_LIMIT + 1)
                duty = -duty;
            c.duty_hundredths = 16'(duty);
        end
        else if (c.mode == MODE_READ)
        begin
            span  = (encmax_setting == 0) ? ENC_ALL_ONES + 1 : int'(encmax_setting) + 1;
            reach = (span / 2 < 300) ? span / 2 : 300;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    step = int'($urandom_range(0, 2 * reach)) - reach;
                6, 7:
                begin
                    // Moves right at the unwrap boundary.
                    step = (span - 1) / 2 + int'($urandom_range(0, 2)) - 1;
                    if ($urandom_range(0, 1) == 1)
                        step = -step;
                end
                8:
                    step = int'($urandom_range(0, 65535)) - raw_position;
                default:
                    step = int'($urandom_range(0, span - 1));
            endcase
            raw_position = raw_position + step;
            if (step != 65535 - (raw_position - step) || raw_position > 65535)
                raw_position = ((raw_position % span) + span) % span;
            c.encoder_count = 16'(raw_position);
        end
        return c;
    endfunction

    task automatic queue_command(mode_t m, int duty, dir_t dir, int count);
        cmd_t c;
        c.mode              = m;
        c.duty_hundredths   = 16'(duty);
        c.direction_request = dir;
        c.encoder_count     = 16'(count);
        cmd_backlog.push_back(c);
    endtask

    task automatic report_mismatch(string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, should be %0h", field, got, want));
    endtask

    task automatic check_status(res_t got);
        res_t want;
        if (status_due.size() == 0)
        begin
            report_mismatch("status returned with no request outstanding");
            return;
        end
        want = status_due.pop_front();
        check_field("bridge_in1", 32'(got.bridge_in1), 32'(want.bridge_in1));
        check_field("bridge_in2", 32'(got.bridge_in2), 32'(want.bridge_in2));
        check_field("compare_value", 32'(got.compare_value), 32'(want.compare_value));
        check_field("direction_now", 32'(got.direction_now), 32'(want.direction_now));
        check_field("duty_percent", 32'(got.duty_percent), 32'(want.duty_percent));
        check_field("total_ticks", 32'(got.total_ticks), 32'(want.total_ticks));
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_PWM_PERIOD)
            period_setting = value;
        else if (idx == CFG_ENCODER_MAX)
            encmax_setting = value;
    endtask

    // Waits until the sender is empty and every status is back, then lets the pipeline settle.
    // The check runs at the falling edge so the driver's updates have landed.
    task automatic wait_for_drain();
        while (cmd_backlog.size() != 0 || cmd_valid || status_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                status_due.push_back(apply_command(cmd));
            if (!cmd_valid || cmd_ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cmd       <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                    send_wait <= draw_gap(send_gap_max);
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Status monitor with receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        int gap;
        if (!rst_n)
        begin
            res_ready    <= 1'b0;
            recv_wait    <= 0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
                check_status(res);
            if (holds_served != holds_requested)
            begin
                holds_served <= holds_served + 1;
                hold_left    <= LONG_HOLD;
                res_ready    <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                res_ready <= (hold_left == 1);
            end
            else if (res_valid && res_ready)
            begin
                gap = draw_gap(recv_gap_max);
                recv_wait <= gap;
                res_ready <= (gap == 0);
            end
            else if (recv_wait != 0)
            begin
                recv_wait <= recv_wait - 1;
                res_ready <= (recv_wait == 1);
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int          p;
        int          n;
        logic [15:0] period_value;
        logic [15:0] encmax_value;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset settings.
        queue_command(MODE_DUTY, 10000, DIR_COAST, 0);
        queue_command(MODE_DUTY, -10000, DIR_COAST, 0);
        queue_command(MODE_DUTY, 32767, DIR_COAST, 0);
        queue_command(MODE_DUTY, -32768, DIR_COAST, 0);
        queue_command(MODE_DUTY, 9, DIR_FORWARD, 0);
        queue_command(MODE_DUTY, -9, DIR_FORWARD, 0);
        queue_command(MODE_DUTY, 10, DIR_COAST, 0);
        queue_command(MODE_DUTY, -10, DIR_COAST, 0);
        queue_command(MODE_DUTY, 150, DIR_COAST, 0);
        queue_command(MODE_DUTY, 0, DIR_COAST, 0);
        queue_command(MODE_DIR, 0, DIR_FORWARD, 0);
        queue_command(MODE_DIR, 0, DIR_FORWARD, 0);
        queue_command(MODE_DIR, 0, DIR_BACKWARD, 0);
        queue_command(MODE_DIR, 0, DIR_BRAKE, 0);
        queue_command(MODE_DIR, 0, DIR_COAST, 0);
        queue_command(MODE_READ, 0, DIR_COAST, 32767);
        queue_command(MODE_READ, 0, DIR_COAST, 65535);
        queue_command(MODE_READ, 0, DIR_COAST, 0);
        queue_command(MODE_READ, 0, DIR_COAST, 32768);
        queue_command(MODE_READ, 0, DIR_COAST, 0);
        queue_command(MODE_STOP, 5049, DIR_FORWARD, 1234);
        queue_command(MODE_READ, 0, DIR_COAST, 5);
        queue_command(MODE_DUTY, -99, DIR_COAST, 0);
        wait_for_drain();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin period_value = 16'd0;     encmax_value = 16'd1;     end
                1:       begin period_value = 16'hFFFF;  encmax_value = 16'd0;     end
                2:       begin period_value = 16'd1;     encmax_value = 16'hFFFF;  end
                3:       begin period_value = 16'd100;   encmax_value = 16'd255;   end
                4:       begin period_value = 16'd12345; encmax_value = 16'd2;     end
                5:       begin period_value = 16'hFFFE;  encmax_value = 16'h8000;  end
                default:
                begin
                    period_value = 16'($urandom);
                    encmax_value = 16'($urandom);
                end
            endcase
            write_register(CFG_PWM_PERIOD, period_value);
            write_register(CFG_ENCODER_MAX, encmax_value);
            raw_position = 0;

            send_gap_max = (p % 3 == 0) ? 0 : GAP_MAX;
            recv_gap_max = (p % 4 == 1) ? 0 : GAP_MAX;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                cmd_backlog.push_back(make_command());
            // The sender keeps offering requests while the receiver holds off.
            if (p == 3)
                holds_requested = holds_requested + 1;
            wait_for_drain();
        end

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
